// ----- design/ubp_pkg.sv -----
`timescale 1ns / 1ps
package ubp_pkg;

    localparam int STEP_COUNT = 8;
    localparam int FACTOR_ONE_MIN_DIVIDER = 9;
    localparam logic [23:0] BAUD_SATURATE = 24'hFFFFFF;

    localparam logic [1:0] ST_APPLIED   = 2'd0;
    localparam logic [1:0] ST_UNCHANGED = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_NONE      = 2'd3;

    localparam logic [2:0] CFG_CLOCK    = 3'd0;
    localparam logic [2:0] CFG_MINUEND  = 3'd1;
    localparam logic [2:0] CFG_DIV_MIN  = 3'd2;
    localparam logic [2:0] CFG_DIV_MAX  = 3'd3;
    localparam logic [2:0] CFG_BAUD_MIN = 3'd4;
    localparam logic [2:0] CFG_BAUD_MAX = 3'd5;

    // log2 of each prescaler factor: 1, 2, 8, 16, 64, 128, 512, 1024
    function automatic logic [3:0] factor_shift(input logic [2:0] idx);
        case (idx)
            3'd0: factor_shift = 4'd0;
            3'd1: factor_shift = 4'd1;
            3'd2: factor_shift = 4'd3;
            3'd3: factor_shift = 4'd4;
            3'd4: factor_shift = 4'd6;
            3'd5: factor_shift = 4'd7;
            3'd6: factor_shift = 4'd9;
            default: factor_shift = 4'd10;
        endcase
    endfunction

endpackage

// ----- design/ubp_divider.sv -----
`timescale 1ns / 1ps
module ubp_divider import ubp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [26:0] dividend,
    input  logic [33:0] divisor,
    output logic        done,
    output logic [26:0] quotient
);

    logic [26:0] quot_reg, quot_next;
    logic [33:0] rem_reg, rem_next;
    logic [4:0]  count_reg, count_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [34:0] trial;
    logic [33:0] div_reg, div_next;

    assign trial = {rem_reg, quot_reg[26]} - {1'b0, div_reg};

    always_comb begin
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        div_next   = div_reg;
        done_next  = 1'b0;
        if (start) begin
            quot_next  = dividend;
            rem_next   = '0;
            div_next   = divisor;
            count_next = 5'd0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            if (!trial[34]) begin
                rem_next  = trial[33:0];
                quot_next = {quot_reg[25:0], 1'b1};
            end else begin
                rem_next  = {rem_reg[32:0], quot_reg[26]};
                quot_next = {quot_reg[25:0], 1'b0};
            end
            count_next = count_reg + 5'd1;
            if (count_reg == 5'd26) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ----- design/uart_baud_prescaler_divisor_search.sv -----
`timescale 1ns / 1ps
// UART baud prescaler and divisor search.
// Slave channel s_axis_*: one beat carries a wanted baud rate (tdata[23:0]).
// Master channel m_axis_*: one result beat per request with status, actual
// baud, three prescaler bypass flags and the divisor register byte.
// Configuration: cfg_we/cfg_addr/cfg_wdata write the six limit registers;
// write only while idle.
// An out-of-range rate puts its result beat up in the cycle after it is
// accepted. Otherwise each of up to eight prescaler steps runs a restoring
// division on one shared 27-step divider, and a second one when the divisor
// fits its range; the search ends early when the divisor falls below its minimum.
// The divider serves every division; one request is in work at a time
// and s_axis_tready stays low until its result beat has been taken.
// A stalled master holds the result in the output register; no new request is
// accepted meanwhile.
// Reset (aresetn low, synchronous) restores register defaults and clears the
// applied setting to bypass bits zero and byte zero.
module uart_baud_prescaler_divisor_search import ubp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [25:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // wanted_baud
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // status[1:0], actual_baud[25:2],
                                        // bypass_2x[26], bypass_8x[27],
                                        // bypass_64x[28], divider_byte[36:29]
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV1 = 3'd1;
    localparam logic [2:0] S_W1   = 3'd2;
    localparam logic [2:0] S_DIV2 = 3'd3;
    localparam logic [2:0] S_W2   = 3'd4;
    localparam logic [2:0] S_END  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [25:0] clk_reg;
    logic [8:0]  minuend_reg, dmax_reg;
    logic [7:0]  dmin_reg;
    logic [23:0] bmin_reg, bmax_reg;
    logic [2:0]  abits_reg;
    logic [7:0]  abyte_reg;

    logic [2:0]  state_reg;
    logic [23:0] want_reg;
    logic [2:0]  idx_reg;
    logic [25:0] d_reg;
    logic        found_reg;
    logic [26:0] bdelta_reg, bbaud_reg;
    logic [2:0]  bbits_reg;
    logic [7:0]  bbyte_reg;
    logic [39:0] out_reg;

    logic        dv_start, dv_done;
    logic [26:0] dv_dividend, dv_quot;
    logic [33:0] dv_divisor;
    logic [26:0] rounded, delta;
    logic [25:0] lim;
    logic [7:0]  byte_cand;
    logic [23:0] sat_baud;
    logic [3:0]  sh;

    assign sh = factor_shift(idx_reg);
    assign dv_dividend = {clk_reg, 1'b0};
    assign rounded = (dv_quot + 27'd1) >> 1;
    assign lim = (idx_reg == 3'd0) ? 26'(FACTOR_ONE_MIN_DIVIDER) : {18'd0, dmin_reg};
    assign delta = (rounded >= {3'd0, want_reg}) ? rounded - {3'd0, want_reg}
                                                 : {3'd0, want_reg} - rounded;
    assign byte_cand = minuend_reg[7:0] - d_reg[7:0];
    assign sat_baud = (bbaud_reg > {3'd0, BAUD_SATURATE}) ? BAUD_SATURATE : bbaud_reg[23:0];

    always_comb begin
        dv_start = 1'b0;
        dv_divisor = '0;
        if (state_reg == S_DIV1) begin
            dv_start = 1'b1;
            dv_divisor = {10'd0, want_reg} << sh;
        end else if (state_reg == S_DIV2) begin
            dv_start = 1'b1;
            dv_divisor = {8'd0, d_reg} << sh;
        end
    end

    ubp_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start),
        .dividend(dv_dividend), .divisor(dv_divisor),
        .done(dv_done), .quotient(dv_quot)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_reg     <= 26'd12000000;
            minuend_reg <= 9'd256;
            dmin_reg    <= 8'd2;
            dmax_reg    <= 9'd255;
            bmin_reg    <= 24'd50;
            bmax_reg    <= 24'd3000000;
            abits_reg   <= '0;
            abyte_reg   <= '0;
            state_reg   <= S_IDLE;
            found_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_CLOCK:    clk_reg     <= cfg_wdata;
                    CFG_MINUEND:  minuend_reg <= cfg_wdata[8:0];
                    CFG_DIV_MIN:  dmin_reg    <= cfg_wdata[7:0];
                    CFG_DIV_MAX:  dmax_reg    <= cfg_wdata[8:0];
                    CFG_BAUD_MIN: bmin_reg    <= cfg_wdata[23:0];
                    CFG_BAUD_MAX: bmax_reg    <= cfg_wdata[23:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        want_reg  <= s_axis_tdata;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        if (s_axis_tdata == 24'd0 || s_axis_tdata < bmin_reg
                                || s_axis_tdata > bmax_reg) begin
                            out_reg   <= {38'd0, ST_RANGE};
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_DIV1;
                        end
                    end
                end
                S_DIV1: state_reg <= S_W1;
                S_W1: begin
                    if (dv_done) begin
                        d_reg <= rounded[25:0];
                        if (rounded[25:0] < lim) begin
                            state_reg <= S_END;
                        end else if (rounded[25:0] != 26'd0
                                && rounded[25:0] <= {17'd0, dmax_reg}) begin
                            state_reg <= S_DIV2;
                        end else if (idx_reg == 3'(STEP_COUNT - 1)) begin
                            state_reg <= S_END;
                        end else begin
                            idx_reg   <= idx_reg + 3'd1;
                            state_reg <= S_DIV1;
                        end
                    end
                end
                S_DIV2: state_reg <= S_W2;
                S_W2: begin
                    if (dv_done) begin
                        if (!found_reg || delta <= bdelta_reg) begin
                            found_reg  <= 1'b1;
                            bdelta_reg <= delta;
                            bbaud_reg  <= rounded;
                            bbits_reg  <= 3'd7 - idx_reg;
                            bbyte_reg  <= byte_cand;
                        end
                        if (idx_reg == 3'(STEP_COUNT - 1)) begin
                            state_reg <= S_END;
                        end else begin
                            idx_reg   <= idx_reg + 3'd1;
                            state_reg <= S_DIV1;
                        end
                    end
                end
                S_END: begin
                    state_reg <= S_OUT;
                    if (!found_reg) begin
                        out_reg <= {38'd0, ST_NONE};
                    end else if (bbits_reg == abits_reg && bbyte_reg == abyte_reg) begin
                        out_reg <= {3'd0, bbyte_reg, bbits_reg, sat_baud, ST_UNCHANGED};
                    end else begin
                        out_reg   <= {3'd0, bbyte_reg, bbits_reg, sat_baud, ST_APPLIED};
                        abits_reg <= bbits_reg;
                        abyte_reg <= bbyte_reg;
                    end
                end
                S_OUT: if (m_axis_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (out_reg[1:0] == ST_RANGE || out_reg[1:0] == ST_NONE))
        |-> out_reg[39:2] == 38'd0) else $error("rejected result not zero");
    a_applied: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_reg[1:0] == ST_APPLIED)
        |-> (abits_reg == out_reg[28:26] && abyte_reg == out_reg[36:29]))
        else $error("applied setting not stored");
`endif

endmodule
